// ----- hdl/pgc_pkg.sv -----
// Shared types and constants for the pairwise gravity and collision pipeline.
// No dependencies; used by pgc_front, pgc_quot and the top level under hdl.
`timescale 1ns / 1ps
package pgc_pkg;

  localparam int VEL_WIDTH  = 32;
  localparam int MASS_WIDTH = 16;
  localparam int SIZE_WIDTH = 12;
  localparam int GRAV_WIDTH = 32;
  localparam int GM_WIDTH   = GRAV_WIDTH + 2 * MASS_WIDTH;
  localparam int MAG_BITS   = 32;

  localparam logic [GRAV_WIDTH-1:0] GRAV_RESET = 32'd4294967;

  typedef struct packed {
    logic apply;
    logic neg_x;
    logic neg_y;
    logic self_des;
    logic other_des;
  } ctl_t;

endpackage

// ----- hdl/pgc_front.sv -----
// Front stages: coordinate differences, squared distance, numerator products
// and the collision test. Depends on pgc_pkg.
`timescale 1ns / 1ps
module pgc_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [COORD_WIDTH-1:0]          self_x,
  input  logic signed [COORD_WIDTH-1:0]          self_y,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0]   self_vx,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0]   self_vy,
  input  logic [pgc_pkg::MASS_WIDTH-1:0]         self_mass,
  input  logic [pgc_pkg::SIZE_WIDTH-1:0]         self_size,
  input  logic                                   self_debris,
  input  logic signed [COORD_WIDTH-1:0]          other_x,
  input  logic signed [COORD_WIDTH-1:0]          other_y,
  input  logic [pgc_pkg::MASS_WIDTH-1:0]         other_mass,
  input  logic [pgc_pkg::SIZE_WIDTH-1:0]         other_size,
  input  logic                                   other_debris,
  input  logic [pgc_pkg::GRAV_WIDTH-1:0]         grav,
  output logic                                   out_valid,
  output logic [2*(COORD_WIDTH+1):0]             out_sq,
  output logic [pgc_pkg::GM_WIDTH+COORD_WIDTH+((3*FRAC_BITS > 32) ? 3*FRAC_BITS-32 : 0):0]
                                                 out_nx,
  output logic [pgc_pkg::GM_WIDTH+COORD_WIDTH+((3*FRAC_BITS > 32) ? 3*FRAC_BITS-32 : 0):0]
                                                 out_ny,
  output logic [pgc_pkg::VEL_WIDTH-1:0]          out_vx,
  output logic [pgc_pkg::VEL_WIDTH-1:0]          out_vy,
  output pgc_pkg::ctl_t                          out_ctl
);

  localparam int AW   = COORD_WIDTH + 1;
  localparam int SW   = 2 * AW + 1;
  localparam int LW   = pgc_pkg::SIZE_WIDTH + FRAC_BITS;
  localparam int GMW  = pgc_pkg::GM_WIDTH;
  localparam int GH   = GMW / 2;
  localparam int PW   = GMW + AW;
  localparam int NSH  = (3 * FRAC_BITS > 32) ? 3 * FRAC_BITS - 32 : 0;
  localparam int NW   = PW + NSH;
  localparam int CMPW = (SW > 2 * LW) ? SW : 2 * LW;
  localparam int VW   = pgc_pkg::VEL_WIDTH;
  localparam int MW   = pgc_pkg::MASS_WIDTH;
  localparam int ZW   = pgc_pkg::SIZE_WIDTH;

  logic                 v1, v2, v3, v4, v5;
  logic [AW-1:0]        s1_dx, s1_dy;
  logic [VW-1:0]        s1_vx, s1_vy, s2_vx, s2_vy, s3_vx, s3_vy, s4_vx, s4_vy;
  logic [MW-1:0]        s1_sm, s1_om;
  logic [ZW-1:0]        s1_hs;
  logic                 s1_deb;
  logic [AW-1:0]        s2_ax, s2_ay, s3_ax, s3_ay;
  logic [2*MW-1:0]      s2_om2;
  logic [LW-1:0]        s2_lim;
  logic                 s2_apply, s2_nx, s2_ny, s2_sle, s2_ole;
  logic [2*AW-1:0]      s3_axsq, s3_aysq;
  logic [GMW-1:0]       s3_gm;
  logic [2*LW-1:0]      s3_limsq;
  logic                 s3_apply, s3_nx, s3_ny, s3_sle, s3_ole;
  logic [SW-1:0]        s4_sq;
  logic [GH+AW-1:0]     s4_pxl, s4_pxh, s4_pyl, s4_pyh;
  pgc_pkg::ctl_t        s4_ctl;
  logic [SW-1:0]        sq_sum;
  logic                 coll;
  logic [PW-1:0]        px_sum, py_sum;

  assign sq_sum = {1'b0, s3_axsq} + {1'b0, s3_aysq};
  assign coll   = CMPW'(sq_sum) < CMPW'(s3_limsq);
  assign px_sum = {s4_pxh, {GH{1'b0}}} + PW'(s4_pxl);
  assign py_sum = {s4_pyh, {GH{1'b0}}} + PW'(s4_pyl);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx  <= {other_x[COORD_WIDTH-1], other_x} - {self_x[COORD_WIDTH-1], self_x};
    s1_dy  <= {other_y[COORD_WIDTH-1], other_y} - {self_y[COORD_WIDTH-1], self_y};
    s1_vx  <= self_vx;
    s1_vy  <= self_vy;
    s1_sm  <= self_mass;
    s1_om  <= other_mass;
    s1_hs  <= {1'b0, self_size[ZW-1:1]} + {1'b0, other_size[ZW-1:1]};
    s1_deb <= self_debris & other_debris;

    s2_nx    <= s1_dx[AW-1];
    s2_ny    <= s1_dy[AW-1];
    s2_ax    <= s1_dx[AW-1] ? ({AW{1'b0}} - s1_dx) : s1_dx;
    s2_ay    <= s1_dy[AW-1] ? ({AW{1'b0}} - s1_dy) : s1_dy;
    s2_apply <= (s1_dx != '0) && (s1_dy != '0) && !s1_deb;
    s2_om2   <= s1_om * s1_om;
    s2_lim   <= {s1_hs, {FRAC_BITS{1'b0}}};
    s2_sle   <= s1_sm <= s1_om;
    s2_ole   <= s1_om <= s1_sm;
    s2_vx    <= s1_vx;
    s2_vy    <= s1_vy;

    s3_axsq  <= s2_ax * s2_ax;
    s3_aysq  <= s2_ay * s2_ay;
    s3_gm    <= grav * s2_om2;
    s3_limsq <= s2_lim * s2_lim;
    s3_ax    <= s2_ax;
    s3_ay    <= s2_ay;
    s3_apply <= s2_apply;
    s3_nx    <= s2_nx;
    s3_ny    <= s2_ny;
    s3_sle   <= s2_sle;
    s3_ole   <= s2_ole;
    s3_vx    <= s2_vx;
    s3_vy    <= s2_vy;

    s4_sq            <= sq_sum;
    s4_ctl.apply     <= s3_apply;
    s4_ctl.neg_x     <= s3_nx;
    s4_ctl.neg_y     <= s3_ny;
    s4_ctl.self_des  <= coll & s3_sle;
    s4_ctl.other_des <= coll & s3_ole;
    s4_pxl           <= s3_gm[GH-1:0] * s3_ax;
    s4_pxh           <= s3_gm[GMW-1:GH] * s3_ax;
    s4_pyl           <= s3_gm[GH-1:0] * s3_ay;
    s4_pyh           <= s3_gm[GMW-1:GH] * s3_ay;
    s4_vx            <= s3_vx;
    s4_vy            <= s3_vy;

    out_sq  <= s4_sq;
    out_nx  <= NW'(px_sum) << NSH;
    out_ny  <= NW'(py_sum) << NSH;
    out_vx  <= s4_vx;
    out_vy  <= s4_vy;
    out_ctl <= s4_ctl;
  end

  assign out_valid = v5;

endmodule

// ----- hdl/pgc_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module pgc_isqrt #(
  parameter int SW    = 67,
  parameter int RW    = 33,
  parameter int SIDEW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [SW-1:0]    in_sq,
  input  logic [SIDEW-1:0] in_side,
  output logic             out_valid,
  output logic [RW-1:0]    out_root,
  output logic [SW-1:0]    out_sq,
  output logic [SIDEW-1:0] out_side
);

  localparam int TW = SW + 2;

  logic             vld  [1:RW];
  logic [RW-1:0]    rt   [1:RW];
  logic [SW-1:0]    rm   [1:RW];
  logic [SW-1:0]    sqp  [1:RW];
  logic [SIDEW-1:0] sd   [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic             v_i;
    logic [RW-1:0]    rt_i;
    logic [SW-1:0]    rm_i;
    logic [SW-1:0]    sq_i;
    logic [SIDEW-1:0] sd_i;
    logic [TW-1:0]    trial;
    logic             take;

    if (k == 0) begin : g_first
      assign v_i  = in_valid;
      assign rt_i = '0;
      assign rm_i = in_sq;
      assign sq_i = in_sq;
      assign sd_i = in_side;
    end else begin : g_rest
      assign v_i  = vld[k];
      assign rt_i = rt[k];
      assign rm_i = rm[k];
      assign sq_i = sqp[k];
      assign sd_i = sd[k];
    end

    assign trial = ({{(TW-RW){1'b0}}, rt_i} << (B + 1))
                 + ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = {2'b00, rm_i} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rt[k+1]  <= take ? (rt_i | ({{(RW-1){1'b0}}, 1'b1} << B)) : rt_i;
      rm[k+1]  <= take ? (rm_i - trial[SW-1:0]) : rm_i;
      sqp[k+1] <= sq_i;
      sd[k+1]  <= sd_i;
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = rt[RW];
  assign out_sq    = sqp[RW];
  assign out_side  = sd[RW];

endmodule

// ----- hdl/pgc_quot.sv -----
// Pipelined restoring divider giving a quotient capped at 2^MAG_BITS.
// One quotient bit per stage after an overflow test. Depends on pgc_pkg.
`timescale 1ns / 1ps
module pgc_quot #(
  parameter int NW    = 113,
  parameter int DNW   = 100,
  parameter int SIDEW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [NW-1:0]                 in_num,
  input  logic [DNW-1:0]                in_den,
  input  logic [SIDEW-1:0]              in_side,
  output logic                          out_valid,
  output logic [pgc_pkg::MAG_BITS:0]    out_mag,
  output logic [SIDEW-1:0]              out_side
);

  localparam int QW  = pgc_pkg::MAG_BITS;
  localparam int RMW = (NW > DNW + QW + 1) ? NW : DNW + QW + 1;

  logic             vld [0:QW];
  logic [RMW-1:0]   rem [0:QW];
  logic [QW-1:0]    q   [0:QW];
  logic             cap [0:QW];
  logic [DNW-1:0]   den [0:QW];
  logic [SIDEW-1:0] sd  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= RMW'(in_num);
    q[0]   <= '0;
    cap[0] <= RMW'(in_num) >= (RMW'(in_den) << QW);
    den[0] <= in_den;
    sd[0]  <= in_side;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [RMW-1:0] sub;
    logic           take;

    assign sub  = RMW'(den[k]) << I;
    assign take = rem[k] >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= take ? (rem[k] - sub) : rem[k];
      q[k+1]   <= take ? (q[k] | ({{(QW-1){1'b0}}, 1'b1} << I)) : q[k];
      cap[k+1] <= cap[k];
      den[k+1] <= den[k];
      sd[k+1]  <= sd[k];
    end
  end

  assign out_valid = vld[QW];
  assign out_mag   = cap[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, q[QW]};
  assign out_side  = sd[QW];

endmodule

// ----- hdl/pairwise_gravity_collision_top.sv -----
// Top level of the pairwise gravity nudge and collision pipeline.
// Depends on pgc_pkg, pgc_front, pgc_isqrt and pgc_quot.
`timescale 1ns / 1ps
// Usage:
//   A pair word is taken at a rising edge with start high; busy is tied low,
//   so a new pair may be issued every cycle.
//   The result word (new_vx, new_vy, self_destroyed, other_destroyed) shows
//   for exactly one cycle with done high, in issue order.
//   The pipeline is made of five front stages, one stage per root bit of the
//   square root, two denominator stages, one overflow test plus 32
//   quotient-bit stages and one output stage.
//   Throughput is one pair per cycle.
//   The receiver cannot stall; results must be taken as they appear.
//   cfg_write loads gravity_constant into the G register; write it only with
//   the pipeline empty.
//   Reset empties the pipeline, drops done and loads G with about 0.001.
module pairwise_gravity_collision_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cfg_write,
  input  logic [pgc_pkg::GRAV_WIDTH-1:0]         gravity_constant,
  input  logic signed [COORD_WIDTH-1:0]          self_x,
  input  logic signed [COORD_WIDTH-1:0]          self_y,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0]   self_vx,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0]   self_vy,
  input  logic [pgc_pkg::MASS_WIDTH-1:0]         self_mass,
  input  logic [pgc_pkg::SIZE_WIDTH-1:0]         self_size,
  input  logic                                   self_debris,
  input  logic signed [COORD_WIDTH-1:0]          other_x,
  input  logic signed [COORD_WIDTH-1:0]          other_y,
  input  logic [pgc_pkg::MASS_WIDTH-1:0]         other_mass,
  input  logic [pgc_pkg::SIZE_WIDTH-1:0]         other_size,
  input  logic                                   other_debris,
  output logic                                   done,
  output logic signed [pgc_pkg::VEL_WIDTH-1:0]   new_vx,
  output logic signed [pgc_pkg::VEL_WIDTH-1:0]   new_vy,
  output logic                                   self_destroyed,
  output logic                                   other_destroyed
);

  localparam int AW   = COORD_WIDTH + 1;
  localparam int SW   = 2 * AW + 1;
  localparam int RW   = AW;
  localparam int NSH  = (3 * FRAC_BITS > 32) ? 3 * FRAC_BITS - 32 : 0;
  localparam int DSH  = (3 * FRAC_BITS < 32) ? 32 - 3 * FRAC_BITS : 0;
  localparam int NW   = pgc_pkg::GM_WIDTH + AW + NSH;
  localparam int PDW  = SW + RW;
  localparam int DNW  = PDW + DSH;
  localparam int VW   = pgc_pkg::VEL_WIDTH;
  localparam int CTW  = $bits(pgc_pkg::ctl_t);
  localparam int ISW  = 2 * NW + 2 * VW + CTW;
  localparam int XSW  = VW + CTW;
  localparam int MGW  = pgc_pkg::MAG_BITS + 1;
  localparam int SMW  = VW + 2;

  logic [pgc_pkg::GRAV_WIDTH-1:0] grav;

  logic                f_valid;
  logic [SW-1:0]       f_sq;
  logic [NW-1:0]       f_nx, f_ny;
  logic [VW-1:0]       f_vx, f_vy;
  pgc_pkg::ctl_t       f_ctl;

  logic                r_valid;
  logic [RW-1:0]       r_root;
  logic [SW-1:0]       r_sq;
  logic [ISW-1:0]      r_side;

  logic                t1_valid, t2_valid;
  logic [2*AW-1:0]     t1_lo;
  logic [2*AW:0]       t1_hi;
  logic [ISW-1:0]      t1_side, t2_side;
  logic [DNW-1:0]      t2_den;
  logic [NW-1:0]       t2_nx, t2_ny;
  logic [VW-1:0]       t2_vx, t2_vy;
  pgc_pkg::ctl_t       t2_ctl;

  logic                qx_valid, qy_valid;
  logic [MGW-1:0]      qx_mag, qy_mag;
  logic [XSW-1:0]      qx_side;
  logic [VW-1:0]       qy_side;
  logic [VW-1:0]       q_vx;
  pgc_pkg::ctl_t       q_ctl;

  logic [SMW-1:0]      sum_x, sum_y;
  logic [VW-1:0]       sat_x, sat_y;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= pgc_pkg::GRAV_RESET;
    end else if (cfg_write) begin
      grav <= gravity_constant;
    end
  end

  pgc_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start & ~busy),
    .self_x       (self_x),
    .self_y       (self_y),
    .self_vx      (self_vx),
    .self_vy      (self_vy),
    .self_mass    (self_mass),
    .self_size    (self_size),
    .self_debris  (self_debris),
    .other_x      (other_x),
    .other_y      (other_y),
    .other_mass   (other_mass),
    .other_size   (other_size),
    .other_debris (other_debris),
    .grav         (grav),
    .out_valid    (f_valid),
    .out_sq       (f_sq),
    .out_nx       (f_nx),
    .out_ny       (f_ny),
    .out_vx       (f_vx),
    .out_vy       (f_vy),
    .out_ctl      (f_ctl)
  );

  pgc_isqrt #(
    .SW    (SW),
    .RW    (RW),
    .SIDEW (ISW)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_sq     (f_sq),
    .in_side   ({f_nx, f_ny, f_vx, f_vy, f_ctl}),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_sq    (r_sq),
    .out_side  (r_side)
  );

  // denominator S * root, split in two partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
    end else begin
      t1_valid <= r_valid;
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_lo   <= r_sq[AW-1:0] * r_root;
    t1_hi   <= r_sq[SW-1:AW] * r_root;
    t1_side <= r_side;
    t2_den  <= DNW'({t1_hi, {AW{1'b0}}} + PDW'(t1_lo)) << DSH;
    t2_side <= t1_side;
  end

  assign {t2_nx, t2_ny, t2_vx, t2_vy, t2_ctl} = t2_side;

  pgc_quot #(
    .NW    (NW),
    .DNW   (DNW),
    .SIDEW (XSW)
  ) u_quot_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t2_valid),
    .in_num    (t2_nx),
    .in_den    (t2_den),
    .in_side   ({t2_vx, t2_ctl}),
    .out_valid (qx_valid),
    .out_mag   (qx_mag),
    .out_side  (qx_side)
  );

  pgc_quot #(
    .NW    (NW),
    .DNW   (DNW),
    .SIDEW (VW)
  ) u_quot_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t2_valid),
    .in_num    (t2_ny),
    .in_den    (t2_den),
    .in_side   (t2_vy),
    .out_valid (qy_valid),
    .out_mag   (qy_mag),
    .out_side  (qy_side)
  );

  assign {q_vx, q_ctl} = qx_side;

  assign sum_x = q_ctl.neg_x ? ({{2{q_vx[VW-1]}}, q_vx} - {1'b0, qx_mag})
                             : ({{2{q_vx[VW-1]}}, q_vx} + {1'b0, qx_mag});
  assign sum_y = q_ctl.neg_y ? ({{2{qy_side[VW-1]}}, qy_side} - {1'b0, qy_mag})
                             : ({{2{qy_side[VW-1]}}, qy_side} + {1'b0, qy_mag});

  // clamp to the signed velocity range
  always_comb begin
    sat_x = sum_x[VW-1:0];
    if (sum_x[SMW-1] && (sum_x[SMW-2:VW-1] != '1)) begin
      sat_x = {1'b1, {(VW-1){1'b0}}};
    end else if (!sum_x[SMW-1] && (sum_x[SMW-2:VW-1] != '0)) begin
      sat_x = {1'b0, {(VW-1){1'b1}}};
    end
    sat_y = sum_y[VW-1:0];
    if (sum_y[SMW-1] && (sum_y[SMW-2:VW-1] != '1)) begin
      sat_y = {1'b1, {(VW-1){1'b0}}};
    end else if (!sum_y[SMW-1] && (sum_y[SMW-2:VW-1] != '0)) begin
      sat_y = {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qx_valid & qy_valid;
    end
  end

  always_ff @(posedge clk) begin
    new_vx          <= q_ctl.apply ? sat_x : q_vx;
    new_vy          <= q_ctl.apply ? sat_y : qy_side;
    self_destroyed  <= q_ctl.self_des;
    other_destroyed <= q_ctl.other_des;
  end

endmodule

// ----- tb/pgc_checker.sv -----
// Checker for the pairwise gravity and collision pipeline: predicts each pair word
// from the handshakes it watches and compares the result words in order.
// Depends on pgc_pkg; instantiated beside the block by pairwise_gravity_collision_top_tb.
`timescale 1ns / 1ps
module pgc_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               cfg_write,
  input  logic [pgc_pkg::GRAV_WIDTH-1:0]     gravity_constant,
  input  logic signed [31:0]                 self_x,
  input  logic signed [31:0]                 self_y,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0] self_vx,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0] self_vy,
  input  logic [pgc_pkg::MASS_WIDTH-1:0]     self_mass,
  input  logic [pgc_pkg::SIZE_WIDTH-1:0]     self_size,
  input  logic                               self_debris,
  input  logic signed [31:0]                 other_x,
  input  logic signed [31:0]                 other_y,
  input  logic [pgc_pkg::MASS_WIDTH-1:0]     other_mass,
  input  logic [pgc_pkg::SIZE_WIDTH-1:0]     other_size,
  input  logic                               other_debris,
  input  logic                               done,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0] new_vx,
  input  logic signed [pgc_pkg::VEL_WIDTH-1:0] new_vy,
  input  logic                               self_destroyed,
  input  logic                               other_destroyed,
  output int                                 fails,
  output int                                 pending
);

  localparam int FRAC = 16;

  typedef logic [255:0] wide_t;

  typedef struct {
    logic signed [pgc_pkg::VEL_WIDTH-1:0] vx;
    logic signed [pgc_pkg::VEL_WIDTH-1:0] vy;
    logic                                 self_des;
    logic                                 other_des;
  } outcome_t;

  logic [pgc_pkg::GRAV_WIDTH-1:0] g_reg;
  outcome_t                       awaited[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  function automatic logic signed [pgc_pkg::VEL_WIDTH-1:0] nudge(input wide_t base,
      input longint d, input wide_t den, input longint v);
    wide_t  ad, q;
    longint mag, sum;
    ad = d < 0 ? wide_t'(-d) : wide_t'(d);
    q = (base * ad) / den;
    mag = (q >= (wide_t'(1) << 32)) ? (longint'(1) << 32) : longint'(q[63:0]);
    sum = d < 0 ? v - mag : v + mag;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[pgc_pkg::VEL_WIDTH-1:0];
  endfunction

  function automatic outcome_t predict_pair();
    outcome_t o;
    longint   dx, dy;
    wide_t    ax, ay, s, r, c, den, base, lim;
    dx = longint'(other_x) - longint'(self_x);
    dy = longint'(other_y) - longint'(self_y);
    ax = dx < 0 ? wide_t'(-dx) : wide_t'(dx);
    ay = dy < 0 ? wide_t'(-dy) : wide_t'(dy);
    s = ax * ax + ay * ay;
    o.vx = self_vx;
    o.vy = self_vy;
    if (dx != 0 && dy != 0 && !(self_debris && other_debris)) begin
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (wide_t'(1) << b);
        if (c * c <= s) r = c;
      end
      den = (s * r) << 32;
      base = (wide_t'(g_reg) * wide_t'(other_mass) * wide_t'(other_mass)) << (3 * FRAC);
      o.vx = nudge(base, dx, den, longint'(self_vx));
      o.vy = nudge(base, dy, den, longint'(self_vy));
    end
    lim = wide_t'(self_size / 2 + other_size / 2) << FRAC;
    o.self_des = 1'b0;
    o.other_des = 1'b0;
    if (s < lim * lim) begin
      o.self_des = self_mass <= other_mass;
      o.other_des = other_mass <= self_mass;
    end
    return o;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
    g_reg = pgc_pkg::GRAV_RESET;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      g_reg = pgc_pkg::GRAV_RESET;
      awaited.delete();
    end else begin
      if (done) begin
        if (awaited.size() == 0) begin
          $display("[%0t] result word with nothing outstanding", $realtime);
          fails++;
        end else begin
          want = awaited.pop_front();
          if (new_vx !== want.vx) report("new_vx", new_vx, want.vx);
          if (new_vy !== want.vy) report("new_vy", new_vy, want.vy);
          if (self_destroyed !== want.self_des)
            report("self_destroyed", self_destroyed, want.self_des);
          if (other_destroyed !== want.other_des)
            report("other_destroyed", other_destroyed, want.other_des);
        end
      end
      if (cfg_write) g_reg = gravity_constant;
      if (start && !busy) awaited.push_back(predict_pair());
    end
    pending = awaited.size();
  end

endmodule

// ----- tb/pairwise_gravity_collision_top_tb.sv -----
// Stimulus and verdict for the pairwise gravity and collision pipeline.
// Depends on pgc_pkg, pgc_checker and the block under hdl.
`timescale 1ns / 1ps
module pairwise_gravity_collision_top_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PAIRS = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_write = 1'b0;
  logic [pgc_pkg::GRAV_WIDTH-1:0] gravity_constant = '0;
  logic signed [31:0] self_x = '0, self_y = '0, other_x = '0, other_y = '0;
  logic signed [pgc_pkg::VEL_WIDTH-1:0] self_vx = '0, self_vy = '0;
  logic [pgc_pkg::MASS_WIDTH-1:0] self_mass = '0, other_mass = '0;
  logic [pgc_pkg::SIZE_WIDTH-1:0] self_size = '0, other_size = '0;
  logic self_debris = 1'b0, other_debris = 1'b0;
  logic done, self_destroyed, other_destroyed;
  logic signed [pgc_pkg::VEL_WIDTH-1:0] new_vx, new_vy;
  int fails, pending;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pairwise_gravity_collision_top dut (
    .clk, .rst, .start, .busy, .cfg_write, .gravity_constant,
    .self_x, .self_y, .self_vx, .self_vy, .self_mass, .self_size, .self_debris,
    .other_x, .other_y, .other_mass, .other_size, .other_debris,
    .done, .new_vx, .new_vy, .self_destroyed, .other_destroyed
  );

  pgc_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pairwise_gravity_collision_top verification failed");
      $finish;
    end
  end

  // leaves start high; the caller drops it when it idles
  task automatic issue(input logic [31:0] sx, sy, vx, vy, input logic [15:0] sm,
                       input logic [11:0] ss, input logic sd, input logic [31:0] ox, oy,
                       input logic [15:0] om, input logic [11:0] os, input logic od);
    self_x <= sx; self_y <= sy; self_vx <= vx; self_vy <= vy;
    self_mass <= sm; self_size <= ss; self_debris <= sd;
    other_x <= ox; other_y <= oy; other_mass <= om; other_size <= os; other_debris <= od;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic load_gravity(input logic [31:0] g);
    hold_off(1);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    cfg_write <= 1'b1;
    gravity_constant <= g;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] spread();
    int k;
    logic [31:0] d;
    k = $urandom_range(2, 30);
    d = $urandom_range(0, (1 << k) - 1);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  task automatic random_pair(input bit quiet);
    logic [31:0] sx, sy, ox, oy, vx, vy;
    logic [15:0] sm, om;
    int mode;
    mode = $urandom_range(0, 9);
    sx = mode == 0 ? $urandom : spread();
    sy = mode == 0 ? $urandom : spread();
    ox = mode == 0 ? $urandom : sx + spread();
    oy = mode == 0 ? $urandom : sy + spread();
    if (mode == 1) ox = sx;
    if (mode == 2) oy = sy;
    vx = $urandom_range(0, 1) ? $urandom : spread();
    vy = $urandom_range(0, 1) ? $urandom : spread();
    sm = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 64))
                                   : 16'($urandom_range(1, 65535));
    om = $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 64))
                                   : 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 7) == 0) om = sm;
    issue(sx, sy, vx, vy, sm, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
          ox, oy, om, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    if (!quiet && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(32'h0, 32'h0, 32'h0, 32'h0, 16'd100, 12'd0, 1'b0,
          32'h0001_0000, 32'h0001_0000, 16'd1000, 12'd0, 1'b0);
    issue(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 12'hFFF, 1'b0,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 12'hFFF, 1'b0);
    issue(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 12'd0, 1'b1,
          32'h8000_0000, 32'h8000_0000, 16'hFFFF, 12'd0, 1'b0);
    issue(32'h0, 32'h0, 32'h7FFF_0000, 32'h8001_0000, 16'd5, 12'd4, 1'b0,
          32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 12'd4, 1'b0);
    issue(32'h0, 32'h0, 32'h1234, 32'h5678, 16'd7, 12'd10, 1'b1,
          32'h0001_0000, 32'h0002_0000, 16'd900, 12'd10, 1'b1);
    issue(32'h0, 32'h0, 32'h1234, 32'h5678, 16'd7, 12'd10, 1'b0,
          32'h0, 32'h0003_0000, 16'd900, 12'd10, 1'b0);
    issue(32'h0, 32'h0, 32'h1234, 32'h5678, 16'd7, 12'd10, 1'b0,
          32'h0003_0000, 32'h0, 16'd900, 12'd10, 1'b0);
    issue(32'h0005_0000, 32'h0005_0000, 32'h0, 32'h0, 16'd40, 12'd1, 1'b0,
          32'h0005_0000, 32'h0005_0000, 16'd40, 12'd1, 1'b0);
    issue(32'h0005_0000, 32'h0005_0000, 32'h0, 32'h0, 16'd40, 12'd2, 1'b0,
          32'h0005_0000, 32'h0005_0000, 16'd40, 12'd2, 1'b0);
    issue(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 12'd20, 1'b0,
          32'h0003_0000, 32'h0004_0000, 16'd0, 12'd20, 1'b0);
    issue(32'h0, 32'h0, 32'h0, 32'h0, 16'd0, 12'd20, 1'b0,
          32'h0003_0000, 32'h0004_0000, 16'd30, 12'd0, 1'b1);
    issue(32'h0, 32'h0, 32'h0, 32'h0, 16'd300, 12'd20, 1'b1,
          32'h0003_0000, 32'hFFFC_0000, 16'd30, 12'd0, 1'b0);
    issue(32'h0, 32'h0, 32'h0, 32'h0, 16'd300, 12'd9, 1'b0,
          32'h0004_0000, 32'h0003_0000, 16'd30, 12'd0, 1'b0);
    issue(32'h0, 32'h0, 32'h0, 32'h0, 16'd300, 12'd10, 1'b0,
          32'h0003_0000, 32'h0004_0000, 16'd30, 12'd1, 1'b0);
    issue(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 16'd3, 12'd0, 1'b0,
          32'h0, 32'hFFFF_FFFF, 16'hFFFF, 12'd0, 1'b0);
    hold_off(3);

    load_gravity(32'hFFFF_FFFF);
    for (int i = 0; i < 100; i++) random_pair(1'b0);
    load_gravity(32'h0);
    for (int i = 0; i < 80; i++) random_pair(1'b0);
    load_gravity($urandom);
    for (int i = 0; i < 120; i++) random_pair(1'b0);
    load_gravity(pgc_pkg::GRAV_RESET);
    for (int i = 0; i < 90; i++) random_pair(1'b0);
    for (int i = 0; i < 60; i++) random_pair(1'b1);
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0)
      $display("pairwise_gravity_collision_top verification clean");
    else
      $display("pairwise_gravity_collision_top verification failed");
    $finish;
  end

endmodule

// ----- pairwise_gravity_collision_top.f -----
hdl/pgc_pkg.sv
hdl/pgc_front.sv
hdl/pgc_isqrt.sv
hdl/pgc_quot.sv
hdl/pairwise_gravity_collision_top.sv
tb/pgc_checker.sv
tb/pairwise_gravity_collision_top_tb.sv
